// ===== sv/mrt_pkg.sv =====
// Package for the mapped region table: field widths, codes and the request
// and response word types. No dependencies.
package mrt_pkg;

    // fixed payload widths
    localparam int ADDR_W  = 38;
    localparam int PROT_W  = 8;
    localparam int SHARE_W = 2;
    localparam int FD_W    = 8;
    localparam int SLOT_W  = 4;
    localparam int EFD_W   = 4;

    // lowest base address a map may receive
    localparam logic [31:0] MAP_FLOOR = 32'hC000_0000;

    // request kinds
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    // response status
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // share modes
    localparam logic [SHARE_W-1:0] SHARE_PRIVATE = 2'd0;
    localparam logic [SHARE_W-1:0] SHARE_SHARED  = 2'd1;

    // protection bits
    localparam int PROT_RD_BIT     = 0;
    localparam int PROT_WR_BIT     = 1;
    localparam int PROT_VALID_BITS = 3;

    // shared adder operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_RND
    } t_alu_op;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] map_offset;
        logic [PROT_W-1:0] prot;
        logic [SHARE_W-1:0] share_mode;
        logic [FD_W-1:0]   fd;
        logic              file_open;
        logic              file_readable;
        logic              file_writable;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] result_addr;
        logic [SLOT_W-1:0] slot;
        logic              entry_freed;
        logic              writeback_needed;
        logic [ADDR_W-1:0] writeback_offset;
        logic [EFD_W-1:0]  entry_fd;
    } t_rsp;

endpackage

// ===== sv/mrt_if.sv =====
// Valid/ready channel interfaces for the mapped region table.
// Depends on mrt_pkg for the request and response word types.
interface mrt_req_if;
    logic          valid;
    logic          ready;
    mrt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrt_rsp_if;
    logic          valid;
    logic          ready;
    mrt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mapped_region_table.sv =====
// Mapped region table: a request word is taken only while the block is idle; a finished
// response waits in an output register while the next request is taken. A request walks
// the entry memory, one entry per cycle through a single read port, unless it fails its
// field checks; one shared adder does the address sums and most of the compares. Reset
// needs no clearing pass: the entries live in memory, and reset marks every entry free by
// clearing the in-use flip-flops.
module mapped_region_table #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 12,
    parameter int FILE_SLOTS = 16,
    parameter int VA_BITS    = 38
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrt_req_if.sink    i_req,
    mrt_rsp_if.source  o_rsp
);

    localparam int AW     = ((VA_BITS > mrt_pkg::ADDR_W) ? VA_BITS : mrt_pkg::ADDR_W) + 2;
    localparam int PAD_A  = AW - mrt_pkg::ADDR_W;
    localparam int PAD_V  = AW - VA_BITS;
    localparam int SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int FDL_W  = mrt_pkg::FD_W + 1;
    localparam logic [FDL_W-1:0] FILE_LIM   = FDL_W'(FILE_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(ENTRIES);
    localparam logic [AW-1:0]    VA_LIMIT   = {{(AW-VA_BITS-1){1'b0}}, 1'b1, {VA_BITS{1'b0}}};
    localparam logic [AW-1:0]    FLOOR_W    = {{(AW-32){1'b0}}, mrt_pkg::MAP_FLOOR};

    typedef struct packed {
        logic [VA_BITS-1:0] start;
        logic [VA_BITS-1:0] len;
        logic [VA_BITS-1:0] offset;
        logic [2:0]         prot;
        logic               shared;
        logic [3:0]         file;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PREP,
        S_SCAN,
        S_MEVAL,
        S_UEVAL,
        S_UDIFF,
        S_UWB,
        S_ULEN,
        S_UOFF,
        S_DONE
    } t_state;

    // control state
    t_state             r_state, n_state;
    logic [ENTRIES-1:0] r_used, n_used;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rd_vld, n_rd_vld;
    logic               r_found, n_found;
    logic               r_rsp_vld, n_rsp_vld;

    // working registers
    mrt_pkg::t_req      r_req, n_req;
    logic [AW-1:0]      r_len_up, n_len_up;
    logic [AW-1:0]      r_req_end, n_req_end;
    logic [AW-1:0]      r_base, n_base;
    logic [AW-1:0]      r_tmp, n_tmp;
    logic [AW-1:0]      r_hit_end, n_hit_end;
    t_entry             r_hit, n_hit;
    logic [SW-1:0]      r_slot, n_slot;
    logic               r_at_start, n_at_start;
    logic               r_whole, n_whole;
    logic [SW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_rd_used, n_rd_used;
    mrt_pkg::t_rsp      r_res, n_res;
    mrt_pkg::t_rsp      r_rsp, n_rsp;

    // entry memory
    t_entry             mem [ENTRIES];
    t_entry             r_rd_data;
    logic [SW-1:0]      rd_addr;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    t_entry             wr_data;

    // shared adder ports
    mrt_pkg::t_alu_op   alu_op;
    logic [AW-1:0]      alu_a, alu_b, alu_c, alu_y;
    logic               alu_lt, alu_eq, alu_gt;

    logic [AW-1:0]      addr_w;
    logic               map_bad, unmap_bad;
    logic [SW+3:0]      slot_x;
    logic [3:0]         slot4;
    mrt_pkg::t_rsp      rsp_reject;

    mrt_alu #(
        .AW        (AW),
        .PAGE_BITS (PAGE_BITS)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_c  (alu_c),
        .o_y  (alu_y),
        .o_lt (alu_lt),
        .o_eq (alu_eq)
    );

    assign alu_gt = !alu_lt && !alu_eq;
    assign addr_w = {{PAD_A{1'b0}}, r_req.start_addr};
    assign slot_x = {4'b0, r_slot};
    assign slot4  = slot_x[3:0];
    assign rd_addr = r_cnt[SW-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        rsp_reject        = '0;
        rsp_reject.status = mrt_pkg::STATUS_REJECT;
    end

    // request field checks
    always_comb begin
        map_bad = (r_req.start_addr != '0) || (r_req.length == '0)
               || (r_req.map_offset != '0) || (r_req.share_mode > mrt_pkg::SHARE_SHARED)
               || (r_req.prot[mrt_pkg::PROT_W-1:mrt_pkg::PROT_VALID_BITS] != '0)
               || ({1'b0, r_req.fd} >= FILE_LIM) || !r_req.file_open
               || (r_req.prot[mrt_pkg::PROT_RD_BIT] && !r_req.file_readable)
               || (r_req.prot[mrt_pkg::PROT_WR_BIT] && (r_req.share_mode == mrt_pkg::SHARE_SHARED)
                   && !r_req.file_writable);
        unmap_bad = (r_req.length == '0) || (r_req.start_addr[PAGE_BITS-1:0] != '0);
    end

    // sequencer and datapath next values
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        n_found    = r_found;
        n_rsp_vld  = r_rsp_vld && !o_rsp.ready;
        n_req      = r_req;
        n_len_up   = r_len_up;
        n_req_end  = r_req_end;
        n_base     = r_base;
        n_tmp      = r_tmp;
        n_hit_end  = r_hit_end;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_at_start = r_at_start;
        n_whole    = r_whole;
        n_rd_idx   = rd_addr;
        n_rd_used  = r_used[rd_addr];
        n_res      = r_res;
        n_rsp      = r_rsp;
        alu_op     = mrt_pkg::ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        alu_c      = '0;
        wr_en      = 1'b0;
        wr_addr    = r_slot;
        wr_data    = r_hit;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_state = S_CHECK;
                end
            end

            // round the length up to pages while the fields are checked
            S_CHECK: begin
                alu_op   = mrt_pkg::ALU_RND;
                alu_a    = {{PAD_A{1'b0}}, r_req.length};
                n_len_up = alu_y;
                n_cnt    = '0;
                n_found  = 1'b0;
                n_base   = FLOOR_W;
                if (r_req.kind == mrt_pkg::KIND_MAP) begin
                    if (map_bad) begin
                        n_res   = rsp_reject;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    if (unmap_bad) begin
                        n_res   = rsp_reject;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end

            // end of the range to unmap
            S_PREP: begin
                alu_op    = mrt_pkg::ALU_ADD;
                alu_a     = addr_w;
                alu_b     = r_len_up;
                n_req_end = alu_y;
                n_state   = S_SCAN;
            end

            // one entry per cycle; the read data and its valid flag are registered behind the counter
            S_SCAN: begin
                n_rd_vld = (r_cnt < CNT_LAST);
                n_cnt    = r_cnt + 1'b1;
                alu_op   = mrt_pkg::ALU_ADD;
                alu_a    = {{PAD_V{1'b0}}, r_rd_data.start};
                alu_b    = {{PAD_V{1'b0}}, r_rd_data.len};
                alu_c    = (r_req.kind == mrt_pkg::KIND_MAP) ? r_base : addr_w;
                if (r_rd_vld) begin
                    if (r_req.kind == mrt_pkg::KIND_MAP) begin
                        // starts and lengths stay page aligned, so the end needs no rounding
                        if (r_rd_used && alu_gt) begin
                            n_base = alu_y;
                        end
                        if (!r_rd_used && !r_found) begin
                            n_found = 1'b1;
                            n_slot  = r_rd_idx;
                        end
                    end else begin
                        if (r_rd_used && !r_found && alu_gt
                            && (addr_w >= {{PAD_V{1'b0}}, r_rd_data.start})) begin
                            n_found   = 1'b1;
                            n_slot    = r_rd_idx;
                            n_hit     = r_rd_data;
                            n_hit_end = alu_y;
                        end
                    end
                end
                if (r_cnt == CNT_LAST) begin
                    n_state = (r_req.kind == mrt_pkg::KIND_MAP) ? S_MEVAL : S_UEVAL;
                end
            end

            // place the new region unless no entry is free or it reaches the top of the space
            S_MEVAL: begin
                alu_op = mrt_pkg::ALU_ADD;
                alu_a  = r_base;
                alu_b  = r_len_up;
                alu_c  = VA_LIMIT;
                if (!r_found || !alu_lt) begin
                    n_res = rsp_reject;
                end else begin
                    wr_en          = 1'b1;
                    wr_addr        = r_slot;
                    wr_data.start  = r_base[VA_BITS-1:0];
                    wr_data.len    = r_len_up[VA_BITS-1:0];
                    wr_data.offset = '0;
                    wr_data.prot   = r_req.prot[mrt_pkg::PROT_VALID_BITS-1:0];
                    wr_data.shared = r_req.share_mode[0];
                    wr_data.file   = r_req.fd[3:0];
                    n_used[r_slot] = 1'b1;
                    n_res                  = '0;
                    n_res.status           = mrt_pkg::STATUS_OK;
                    n_res.result_addr      = r_base[mrt_pkg::ADDR_W-1:0];
                    n_res.slot             = slot4;
                    n_res.entry_fd         = r_req.fd[3:0];
                end
                n_state = S_DONE;
            end

            // range must stay inside the region and touch one of its ends
            S_UEVAL: begin
                alu_op     = mrt_pkg::ALU_ADD;
                alu_a      = r_req_end;
                alu_b      = '0;
                alu_c      = r_hit_end;
                n_at_start = (addr_w == {{PAD_V{1'b0}}, r_hit.start});
                n_whole    = (addr_w == {{PAD_V{1'b0}}, r_hit.start})
                          && (r_len_up == {{PAD_V{1'b0}}, r_hit.len});
                if (!r_found || alu_gt
                    || ((addr_w != {{PAD_V{1'b0}}, r_hit.start}) && !alu_eq)) begin
                    n_res   = rsp_reject;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UDIFF;
                end
            end

            S_UDIFF: begin
                alu_op  = mrt_pkg::ALU_SUB;
                alu_a   = addr_w;
                alu_b   = {{PAD_V{1'b0}}, r_hit.start};
                n_tmp   = alu_y;
                n_state = S_UWB;
            end

            // file offset of the first unmapped byte
            S_UWB: begin
                alu_op = mrt_pkg::ALU_ADD;
                alu_a  = {{PAD_V{1'b0}}, r_hit.offset};
                alu_b  = r_tmp;
                n_res                  = '0;
                n_res.status           = mrt_pkg::STATUS_OK;
                n_res.slot             = slot4;
                n_res.entry_freed      = r_whole;
                n_res.writeback_needed = r_hit.shared;
                n_res.writeback_offset = r_hit.shared ? alu_y[mrt_pkg::ADDR_W-1:0] : '0;
                n_res.entry_fd         = r_hit.file;
                n_state = S_ULEN;
            end

            S_ULEN: begin
                alu_op  = mrt_pkg::ALU_SUB;
                alu_a   = {{PAD_V{1'b0}}, r_hit.len};
                alu_b   = r_len_up;
                n_tmp   = alu_y;
                n_state = S_UOFF;
            end

            // free the entry, or trim it from the front or the back
            S_UOFF: begin
                alu_op = mrt_pkg::ALU_ADD;
                alu_a  = {{PAD_V{1'b0}}, r_hit.offset};
                alu_b  = r_len_up;
                if (r_whole) begin
                    n_used[r_slot] = 1'b0;
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = r_slot;
                    wr_data     = r_hit;
                    wr_data.len = r_tmp[VA_BITS-1:0];
                    if (r_at_start) begin
                        wr_data.start  = r_req_end[VA_BITS-1:0];
                        wr_data.offset = alu_y[VA_BITS-1:0];
                    end
                end
                n_state = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_rsp_vld || o_rsp.ready) begin
                    n_rsp     = r_res;
                    n_rsp_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_cnt      <= n_cnt;
            r_rd_vld   <= n_rd_vld;
            r_found    <= n_found;
            r_rsp_vld  <= n_rsp_vld;
            r_req      <= n_req;
            r_len_up   <= n_len_up;
            r_req_end  <= n_req_end;
            r_base     <= n_base;
            r_tmp      <= n_tmp;
            r_hit_end  <= n_hit_end;
            r_hit      <= n_hit;
            r_slot     <= n_slot;
            r_at_start <= n_at_start;
            r_whole    <= n_whole;
            r_rd_idx   <= n_rd_idx;
            r_rd_used  <= n_rd_used;
            r_res      <= n_res;
            r_rsp      <= n_rsp;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // a response appears only after the sequencer finished a request
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_vld) |-> $past(r_state == S_DONE))
        else $error("response raised outside the done step");

    // a map never overwrites an entry in use
    a_map_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEVAL && wr_en) |-> !r_used[r_slot])
        else $error("map writes an entry that is in use");

    // an unmap only changes an entry that is in use
    a_unmap_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UOFF) |-> r_used[r_slot])
        else $error("unmap changes a free entry");
`endif

endmodule

// ===== sv/mrt_alu.sv =====
// Shared adder of the mapped region table: add, subtract or round up to a
// page, with an unsigned compare of the result. Depends on mrt_pkg.
module mrt_alu #(
    parameter int AW        = 40,
    parameter int PAGE_BITS = 12
) (
    input  mrt_pkg::t_alu_op i_op,
    input  logic [AW-1:0]    i_a,
    input  logic [AW-1:0]    i_b,
    input  logic [AW-1:0]    i_c,
    output logic [AW-1:0]    o_y,
    output logic             o_lt,
    output logic             o_eq
);

    localparam logic [AW-1:0] PAGE_MASK = {{(AW-PAGE_BITS){1'b0}}, {PAGE_BITS{1'b1}}};

    logic [AW-1:0] addend;
    logic          cin;
    logic [AW-1:0] sum;

    // operand select
    always_comb begin
        case (i_op)
            mrt_pkg::ALU_ADD: begin
                addend = i_b;
                cin    = 1'b0;
            end
            mrt_pkg::ALU_SUB: begin
                addend = ~i_b;
                cin    = 1'b1;
            end
            mrt_pkg::ALU_RND: begin
                addend = PAGE_MASK;
                cin    = 1'b0;
            end
            default: begin
                addend = i_b;
                cin    = 1'b0;
            end
        endcase
    end

    assign sum = i_a + addend + {{(AW-1){1'b0}}, cin};

    // rounding clears the page offset after adding the mask
    assign o_y  = (i_op == mrt_pkg::ALU_RND) ? (sum & ~PAGE_MASK) : sum;
    assign o_lt = o_y < i_c;
    assign o_eq = o_y == i_c;

endmodule
